FILE: src/ssic_pkg.sv
package ssic_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int COORD_BITS   = 16;
  localparam int FIELD_BITS   = 16;
  localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
  localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int SUM_BITS     = PROD_BITS + 1;
  localparam int SEG_BITS     = 4 * COORD_BITS;
  localparam int NUM_OPS      = 6;
  localparam int OP_BITS      = 3;

  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } seg_t;

  typedef enum logic [1:0] {
    STATUS_NONE     = 2'd0,
    STATUS_FOUND    = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [OP_BITS-1:0] {
    OP_S1_A2 = 3'd0,
    OP_S1_B2 = 3'd1,
    OP_S2_A1 = 3'd2,
    OP_S2_B1 = 3'd3,
    OP_IN_A2 = 3'd4,
    OP_IN_B2 = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_RD_J,
    ST_LD_J,
    ST_EVAL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic rd_en;
    idx_t rd_addr;
    logic cap_s1;
    logic cap_s2;
    logic issue;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    cnt_t count;
    logic overflow;
    logic hit;
  } stat_t;

  function automatic coord_t to_coord(input logic signed [FIELD_BITS-1:0] v);
    logic [COORD_BITS+FIELD_BITS-1:0] w;
    w = {{COORD_BITS{v[FIELD_BITS-1]}}, v};
    return w[COORD_BITS-1:0];
  endfunction

  function automatic diff_t sub_ext(input coord_t a, input coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

endpackage

FILE: src/ssic_if.sv
interface ssic_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic signed [ssic_pkg::FIELD_BITS-1:0] start_x;
  logic signed [ssic_pkg::FIELD_BITS-1:0] start_y;
  logic signed [ssic_pkg::FIELD_BITS-1:0] end_x;
  logic signed [ssic_pkg::FIELD_BITS-1:0] end_y;

  modport source (output valid, kind, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, kind, start_x, start_y, end_x, end_y, output ready);
endinterface

interface ssic_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

FILE: src/segment_set_self_intersection_check.sv
// Checks a set of line segments for any intersecting pair. Load items (kind 0)
// append one segment each and are taken one per cycle; a load beyond the
// store's capacity is dropped and marks overflow. A check item (kind 1) returns
// one status item (none, found, empty set, overflow) and empties the set.
// For a stored set without overflow the check walks the pairs in load
// order and stops at the first hit; the pairs go one at a time through the
// single read port of the segment store and the one shared cross-product sign
// unit, which resolves six signs per pair. Empty, single-segment and overflow
// checks skip the pair walk and go straight to the finish step. No input item
// is taken while a check is in progress.
module segment_set_self_intersection_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssic_in_if.sink     in_i,
  ssic_out_if.source  out_o
);

  ssic_pkg::cmd_t  cmd;
  ssic_pkg::stat_t stat;

  ssic_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_kind_i    (in_i.kind),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  ssic_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .start_x_i (in_i.start_x),
    .start_y_i (in_i.start_y),
    .end_x_i   (in_i.end_x),
    .end_y_i   (in_i.end_y),
    .stat_o    (stat)
  );

endmodule

FILE: src/ssic_ram.sv
module ssic_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ssic_dp.sv
module ssic_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ssic_pkg::cmd_t                         cmd_i,
  input  logic signed [ssic_pkg::FIELD_BITS-1:0] start_x_i,
  input  logic signed [ssic_pkg::FIELD_BITS-1:0] start_y_i,
  input  logic signed [ssic_pkg::FIELD_BITS-1:0] end_x_i,
  input  logic signed [ssic_pkg::FIELD_BITS-1:0] end_y_i,
  output ssic_pkg::stat_t                        stat_o
);

  ssic_pkg::cnt_t  count_q, count_d;
  logic            overflow_q, overflow_d;
  logic            full;
  logic            wr_en;
  ssic_pkg::seg_t  wr_seg;
  ssic_pkg::seg_t  rd_seg;
  ssic_pkg::seg_t  s1_q, s2_q;
  ssic_pkg::seg_t  sel_s;
  ssic_pkg::coord_t px, py;
  logic            use_add;
  ssic_pkg::diff_t d0, d1, d2, d3;
  ssic_pkg::prod_t p0_q, p1_q;
  logic            add1_q;
  logic            vld1_q;
  ssic_pkg::op_e   op1_q;
  ssic_pkg::sum_t  res;
  logic            zero_q [ssic_pkg::NUM_OPS];
  logic            neg_q  [ssic_pkg::NUM_OPS];
  logic            colinear;
  logic            cross_s1;
  logic            cross_s2;

  assign full  = (count_q == ssic_pkg::cnt_t'(ssic_pkg::MAX_SEGMENTS));
  assign wr_en = cmd_i.load && !full;

  always_comb begin
    wr_seg.ax = ssic_pkg::to_coord(start_x_i);
    wr_seg.ay = ssic_pkg::to_coord(start_y_i);
    wr_seg.bx = ssic_pkg::to_coord(end_x_i);
    wr_seg.by = ssic_pkg::to_coord(end_y_i);
  end

  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    if (cmd_i.clear) begin
      count_d    = '0;
      overflow_d = 1'b0;
    end else if (cmd_i.load) begin
      if (full) begin
        overflow_d = 1'b1;
      end else begin
        count_d = count_q + ssic_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
      vld1_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      overflow_q <= overflow_d;
      vld1_q     <= cmd_i.issue;
    end
  end

  ssic_ram #(
    .WIDTH (ssic_pkg::SEG_BITS),
    .DEPTH (ssic_pkg::MAX_SEGMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[ssic_pkg::IDX_BITS-1:0]),
    .wdata_i (wr_seg),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rd_seg)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_s1) begin
      s1_q <= rd_seg;
    end
    if (cmd_i.cap_s2) begin
      s2_q <= rd_seg;
    end
  end

  always_comb begin
    sel_s   = s1_q;
    px      = s2_q.ax;
    py      = s2_q.ay;
    use_add = 1'b0;
    case (cmd_i.op)
      ssic_pkg::OP_S1_A2: begin
        px = s2_q.ax;
        py = s2_q.ay;
      end
      ssic_pkg::OP_S1_B2: begin
        px = s2_q.bx;
        py = s2_q.by;
      end
      ssic_pkg::OP_S2_A1: begin
        sel_s = s2_q;
        px    = s1_q.ax;
        py    = s1_q.ay;
      end
      ssic_pkg::OP_S2_B1: begin
        sel_s = s2_q;
        px    = s1_q.bx;
        py    = s1_q.by;
      end
      ssic_pkg::OP_IN_A2: begin
        px      = s2_q.ax;
        py      = s2_q.ay;
        use_add = 1'b1;
      end
      ssic_pkg::OP_IN_B2: begin
        px      = s2_q.bx;
        py      = s2_q.by;
        use_add = 1'b1;
      end
      default: begin
        use_add = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (use_add) begin
      d0 = ssic_pkg::sub_ext(px, sel_s.ax);
      d1 = ssic_pkg::sub_ext(px, sel_s.bx);
      d2 = ssic_pkg::sub_ext(py, sel_s.ay);
      d3 = ssic_pkg::sub_ext(py, sel_s.by);
    end else begin
      d0 = ssic_pkg::sub_ext(sel_s.bx, sel_s.ax);
      d1 = ssic_pkg::sub_ext(py, sel_s.ay);
      d2 = ssic_pkg::sub_ext(sel_s.by, sel_s.ay);
      d3 = ssic_pkg::sub_ext(px, sel_s.ax);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      p0_q   <= ssic_pkg::prod_t'(d0) * ssic_pkg::prod_t'(d1);
      p1_q   <= ssic_pkg::prod_t'(d2) * ssic_pkg::prod_t'(d3);
      add1_q <= use_add;
      op1_q  <= cmd_i.op;
    end
  end

  assign res = add1_q ? (ssic_pkg::sum_t'(p0_q) + ssic_pkg::sum_t'(p1_q))
                      : (ssic_pkg::sum_t'(p0_q) - ssic_pkg::sum_t'(p1_q));

  always_ff @(posedge clk_i) begin
    if (vld1_q) begin
      zero_q[op1_q] <= (res == '0);
      neg_q[op1_q]  <= res[ssic_pkg::SUM_BITS-1];
    end
  end

  assign colinear = zero_q[ssic_pkg::OP_S1_A2] && zero_q[ssic_pkg::OP_S1_B2];
  assign cross_s1 = !zero_q[ssic_pkg::OP_S1_A2] && !zero_q[ssic_pkg::OP_S1_B2]
                    && (neg_q[ssic_pkg::OP_S1_A2] != neg_q[ssic_pkg::OP_S1_B2]);
  assign cross_s2 = !zero_q[ssic_pkg::OP_S2_A1] && !zero_q[ssic_pkg::OP_S2_B1]
                    && (neg_q[ssic_pkg::OP_S2_A1] != neg_q[ssic_pkg::OP_S2_B1]);

  always_comb begin
    stat_o.count    = count_q;
    stat_o.overflow = overflow_q;
    if (colinear) begin
      stat_o.hit = (zero_q[ssic_pkg::OP_IN_A2] || neg_q[ssic_pkg::OP_IN_A2])
                   && (zero_q[ssic_pkg::OP_IN_B2] || neg_q[ssic_pkg::OP_IN_B2]);
    end else begin
      stat_o.hit = cross_s1 && cross_s2;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ssic_pkg::cnt_t'(ssic_pkg::MAX_SEGMENTS))
    else $error("segment count beyond capacity");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_q |-> full)
    else $error("overflow flagged with room left in the store");

endmodule

FILE: src/ssic_ctrl.sv
module ssic_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_kind_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      out_status_o,
  output ssic_pkg::cmd_t  cmd_o,
  input  ssic_pkg::stat_t stat_i
);

  ssic_pkg::state_e  state_q, state_d;
  ssic_pkg::idx_t    i_q, i_d;
  ssic_pkg::idx_t    j_q, j_d;
  logic [ssic_pkg::OP_BITS-1:0] op_q, op_d;
  ssic_pkg::status_e res_q, res_d;
  logic              out_valid_q, out_valid_d;
  ssic_pkg::status_e out_status_q, out_status_d;
  logic              in_acc;

  assign in_ready_o = (state_q == ssic_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssic_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    op_q         <= op_d;
    res_q        <= res_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    op_d         = op_q;
    res_d        = res_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    cmd_o        = '0;
    cmd_o.op     = ssic_pkg::op_e'(op_q);
    case (state_q)
      ssic_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_kind_i) begin
            cmd_o.load = 1'b1;
          end else begin
            state_d = ssic_pkg::ST_FINISH;
            i_d     = '0;
            if (stat_i.overflow) begin
              res_d = ssic_pkg::STATUS_OVERFLOW;
            end else if (stat_i.count == '0) begin
              res_d = ssic_pkg::STATUS_EMPTY;
            end else if (stat_i.count == ssic_pkg::cnt_t'(1)) begin
              res_d = ssic_pkg::STATUS_NONE;
            end else begin
              state_d = ssic_pkg::ST_RD_I;
            end
          end
        end
      end
      ssic_pkg::ST_RD_I: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = i_q;
        state_d       = ssic_pkg::ST_LD_I;
      end
      ssic_pkg::ST_LD_I: begin
        cmd_o.cap_s1 = 1'b1;
        j_d          = i_q + ssic_pkg::idx_t'(1);
        state_d      = ssic_pkg::ST_RD_J;
      end
      ssic_pkg::ST_RD_J: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = j_q;
        state_d       = ssic_pkg::ST_LD_J;
      end
      ssic_pkg::ST_LD_J: begin
        cmd_o.cap_s2 = 1'b1;
        op_d         = '0;
        state_d      = ssic_pkg::ST_EVAL;
      end
      ssic_pkg::ST_EVAL: begin
        cmd_o.issue = (op_q < ssic_pkg::OP_BITS'(ssic_pkg::NUM_OPS));
        op_d        = op_q + 1'b1;
        if (op_q == '1) begin
          if (stat_i.hit) begin
            res_d   = ssic_pkg::STATUS_FOUND;
            state_d = ssic_pkg::ST_FINISH;
          end else if ((ssic_pkg::cnt_t'(j_q) + ssic_pkg::cnt_t'(1)) < stat_i.count) begin
            j_d     = j_q + ssic_pkg::idx_t'(1);
            state_d = ssic_pkg::ST_RD_J;
          end else if ((ssic_pkg::cnt_t'(i_q) + ssic_pkg::cnt_t'(2)) < stat_i.count) begin
            i_d     = i_q + ssic_pkg::idx_t'(1);
            state_d = ssic_pkg::ST_RD_I;
          end else begin
            res_d   = ssic_pkg::STATUS_NONE;
            state_d = ssic_pkg::ST_FINISH;
          end
        end
      end
      ssic_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_q;
          cmd_o.clear  = 1'b1;
          state_d      = ssic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ssic_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;

  a_walk_needs_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssic_pkg::ST_EVAL) |-> (stat_i.count >= ssic_pkg::cnt_t'(2)))
    else $error("pair walk running on fewer than two segments");

  a_later_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssic_pkg::ST_RD_J) |-> (j_q > i_q))
    else $error("inner index not above outer index");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ssic_pkg::ST_FINISH))
    else $error("result raised outside the finish step");

endmodule

FILE: tb/segment_set_self_intersection_check_tb.sv
module segment_set_self_intersection_check_tb;
  import ssic_pkg::*;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_CHECK   = 1'b1;
  localparam int   IDLE_PCT     = 19;
  localparam int   RANDOM_ITEMS = 1350;
  localparam int   QUIET_LIMIT  = 100000;
  localparam int   DRAIN_CYCLES = 64;
  localparam int   DIR_ROWS     = 32;

  localparam int STYLE_WIDE     = 0;
  localparam int STYLE_GRID     = 1;
  localparam int STYLE_PARALLEL = 2;
  localparam int STYLE_EXTREME  = 3;

  typedef logic signed [FIELD_BITS-1:0] field_t;

  typedef struct {
    longint ax;
    longint ay;
    longint bx;
    longint by;
  } seg_rec_t;

  typedef struct {
    logic    kind;
    int      sx;
    int      sy;
    int      ex;
    int      ey;
    int      reps;
    int      dy;
    bit      has_want;
    status_e want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  ssic_in_if  seg_in ();
  ssic_out_if stat_out ();

  segment_set_self_intersection_check dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (seg_in),
    .out_o  (stat_out)
  );

  seg_rec_t held_segs[$];
  bit       held_overflow;
  status_e  status_due[$];

  bit steady;
  int fails;
  int quiet_cycles;
  int loads_sent;
  int checks_sent;
  int status_seen[4];

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_EMPTY},
    '{KIND_LOAD, 0, 0, 10, 10, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_NONE},
    '{KIND_LOAD, 0, 0, 10, 10, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_LOAD, 0, 10, 10, 0, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_FOUND},
    '{KIND_LOAD, 0, 0, 10, 0, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_LOAD, 10, 0, 10, 10, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_NONE},
    '{KIND_LOAD, 0, 0, 10, 0, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_LOAD, 2, 0, 8, 0, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_FOUND},
    '{KIND_LOAD, 0, 0, 10, 0, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_LOAD, 5, 0, 15, 0, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_NONE},
    '{KIND_LOAD, 0, 0, 10, 0, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_LOAD, 5, 0, 5, 5, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_LOAD, 3, 3, 3, 3, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_LOAD, 3, 3, 3, 3, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_FOUND},
    '{KIND_LOAD, -32768, -32768, 32767, 32767, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_LOAD, -32768, 32767, 32767, -32768, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_FOUND},
    '{KIND_LOAD, -32768, 0, 32767, 0, MAX_SEGMENTS, 1, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_NONE},
    '{KIND_LOAD, 0, 0, 1, 1, MAX_SEGMENTS + 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_OVERFLOW},
    '{KIND_CHECK, 0, 0, 0, 0, 1, 0, 1'b1, STATUS_EMPTY},
    '{KIND_LOAD, 7, -7, 7, -7, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_LOAD, 0, 0, 14, -14, 1, 0, 1'b0, STATUS_NONE},
    '{KIND_CHECK, -1, -1, -1, -1, 1, 0, 1'b0, STATUS_NONE}
  };

  function automatic longint widen(input field_t v);
    coord_t c;
    c = coord_t'(v);
    return longint'(c);
  endfunction

  function automatic int sign_of(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic int side_of(input seg_rec_t s, input longint px, input longint py);
    return sign_of((s.bx - s.ax) * (py - s.ay) - (s.by - s.ay) * (px - s.ax));
  endfunction

  function automatic bit lies_on(input seg_rec_t s, input longint px, input longint py);
    return ((px - s.ax) * (px - s.bx) + (py - s.ay) * (py - s.by)) <= 0;
  endfunction

  function automatic bit pair_crosses(input seg_rec_t s1, input seg_rec_t s2);
    int a;
    int b;
    a = side_of(s1, s2.ax, s2.ay);
    b = side_of(s1, s2.bx, s2.by);
    if (a == 0 && b == 0) begin
      return lies_on(s1, s2.ax, s2.ay) && lies_on(s1, s2.bx, s2.by);
    end
    if (a * b >= 0) begin
      return 1'b0;
    end
    a = side_of(s2, s1.ax, s1.ay);
    b = side_of(s2, s1.bx, s1.by);
    return a * b < 0;
  endfunction

  function automatic void store_segment(input field_t sx, input field_t sy,
                                        input field_t ex, input field_t ey);
    seg_rec_t s;
    s.ax = widen(sx);
    s.ay = widen(sy);
    s.bx = widen(ex);
    s.by = widen(ey);
    if (held_segs.size() >= MAX_SEGMENTS) begin
      held_overflow = 1'b1;
    end else begin
      held_segs.push_back(s);
    end
  endfunction

  function automatic status_e judge_set();
    status_e verdict;
    verdict = STATUS_NONE;
    if (held_overflow) begin
      verdict = STATUS_OVERFLOW;
    end else if (held_segs.size() == 0) begin
      verdict = STATUS_EMPTY;
    end else begin
      for (int i = 0; i + 1 < held_segs.size(); i++) begin
        for (int j = i + 1; j < held_segs.size(); j++) begin
          if (verdict == STATUS_NONE && pair_crosses(held_segs[i], held_segs[j])) begin
            verdict = STATUS_FOUND;
          end
        end
      end
    end
    held_segs.delete();
    held_overflow = 1'b0;
    return verdict;
  endfunction

  task automatic push_item(input logic kind, input field_t sx, input field_t sy,
                           input field_t ex, input field_t ey,
                           input bit has_want, input status_e want);
    status_e verdict;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      seg_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    seg_in.valid   <= 1'b1;
    seg_in.kind    <= kind;
    seg_in.start_x <= sx;
    seg_in.start_y <= sy;
    seg_in.end_x   <= ex;
    seg_in.end_y   <= ey;
    @(posedge clk_i);
    while (!seg_in.ready) @(posedge clk_i);
    if (kind == KIND_CHECK) begin
      verdict = judge_set();
      status_due.push_back(has_want ? want : verdict);
      checks_sent++;
    end else begin
      store_segment(sx, sy, ex, ey);
      loads_sent++;
    end
    @(negedge clk_i);
  endtask

  function automatic field_t pick_coord(input int style);
    case (style)
      STYLE_GRID: return field_t'($urandom_range(0, 6) - 3);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return field_t'(-32768);
          1: return field_t'(32767);
          2: return field_t'(0);
          3: return field_t'(-1);
          default: return field_t'($urandom);
        endcase
      end
      default: return field_t'($urandom);
    endcase
  endfunction

  task automatic load_random_segment(input int style, input int idx);
    field_t y;
    if (style == STYLE_PARALLEL) begin
      y = field_t'(idx * 100 + $urandom_range(0, 99) - 32768);
      push_item(KIND_LOAD, pick_coord(STYLE_WIDE), y, pick_coord(STYLE_WIDE), y,
                1'b0, STATUS_NONE);
    end else begin
      push_item(KIND_LOAD, pick_coord(style), pick_coord(style), pick_coord(style),
                pick_coord(style), 1'b0, STATUS_NONE);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    stat_out.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if ((seg_in.valid && seg_in.ready) || (stat_out.valid && stat_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && stat_out.valid && stat_out.ready) begin
      status_seen[stat_out.status]++;
      if (status_due.size() == 0) begin
        $error("status: no item expected, actual %0d", stat_out.status);
        fails++;
      end else if (stat_out.status !== status_due[0]) begin
        $error("status mismatch: expected %0d, actual %0d", status_due[0], stat_out.status);
        fails++;
        void'(status_due.pop_front());
      end else begin
        void'(status_due.pop_front());
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int random_items;
    int round;
    int set_size;
    int style;
    int pick;
    rst_ni          = 1'b0;
    steady          = 1'b0;
    fails           = 0;
    quiet_cycles    = 0;
    held_overflow   = 1'b0;
    seg_in.valid    = 1'b0;
    seg_in.kind     = KIND_LOAD;
    seg_in.start_x  = '0;
    seg_in.start_y  = '0;
    seg_in.end_x    = '0;
    seg_in.end_y    = '0;
    stat_out.ready  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].reps; k++) begin
        push_item(dir_rows[r].kind, field_t'(dir_rows[r].sx),
                  field_t'(dir_rows[r].sy + k * dir_rows[r].dy),
                  field_t'(dir_rows[r].ex),
                  field_t'(dir_rows[r].ey + k * dir_rows[r].dy),
                  dir_rows[r].has_want, dir_rows[r].want);
      end
    end

    random_items = 0;
    round = 0;
    while (random_items < RANDOM_ITEMS) begin
      steady = (round >= 40 && round < 70);
      pick = $urandom_range(0, 99);
      if (pick < 5) set_size = 0;
      else if (pick < 75) set_size = $urandom_range(1, 8);
      else if (pick < 90) set_size = $urandom_range(9, 24);
      else if (pick < 96) set_size = $urandom_range(25, MAX_SEGMENTS - 1);
      else if (pick < 98) set_size = MAX_SEGMENTS;
      else set_size = $urandom_range(MAX_SEGMENTS + 1, MAX_SEGMENTS + 6);
      style = $urandom_range(STYLE_WIDE, STYLE_EXTREME);
      for (int k = 0; k < set_size; k++) begin
        // drop in a stray check now and then to split the set
        if ($urandom_range(0, 99) < 3) begin
          push_item(KIND_CHECK, pick_coord(STYLE_WIDE), pick_coord(STYLE_WIDE),
                    pick_coord(STYLE_WIDE), pick_coord(STYLE_WIDE), 1'b0, STATUS_NONE);
          random_items++;
        end
        load_random_segment(style, k);
      end
      push_item(KIND_CHECK, pick_coord(STYLE_WIDE), pick_coord(STYLE_WIDE),
                pick_coord(STYLE_WIDE), pick_coord(STYLE_WIDE), 1'b0, STATUS_NONE);
      random_items += set_size + 1;
      round++;
    end
    steady = 1'b0;
    seg_in.valid <= 1'b0;

    wait (status_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Loaded %0d segments over %0d checks in %0d random sets",
             loads_sent, checks_sent, round);
    $display("Outcomes: none %0d, found %0d, empty %0d, overflow %0d",
             status_seen[STATUS_NONE], status_seen[STATUS_FOUND],
             status_seen[STATUS_EMPTY], status_seen[STATUS_OVERFLOW]);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
